@@ rtl/core/mvb_pkg.sv @@
package mvb_pkg;

    localparam logic [7:0]  FRAME_START_BYTE = 8'hFD;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;

    localparam logic [7:0]  RESET_SYS_ID     = 8'd1;
    localparam logic [7:0]  RESET_COMP_ID    = 8'd1;
    localparam logic [23:0] RESET_MSG_ID     = 24'd76;
    localparam logic [7:0]  RESET_CRC_SEED   = 8'd152;

    // Configuration register indexes.
    localparam logic [7:0] REG_SYS_ID    = 8'd0;
    localparam logic [7:0] REG_COMP_ID   = 8'd1;
    localparam logic [7:0] REG_MSG_ID    = 8'd2;
    localparam logic [7:0] REG_CRC_SEED  = 8'd3;

    // Output byte positions within the work for one queued byte.
    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_LEN      = 4'd1,
        PH_FLAGS_IN = 4'd2,
        PH_FLAGS_CP = 4'd3,
        PH_SEQ      = 4'd4,
        PH_SYS      = 4'd5,
        PH_COMP     = 4'd6,
        PH_MSG_LO   = 4'd7,
        PH_MSG_MID  = 4'd8,
        PH_MSG_HI   = 4'd9,
        PH_PAYLOAD  = 4'd10,
        PH_CRC_LO   = 4'd11,
        PH_CRC_HI   = 4'd12
    } phase_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One classified payload byte with the header values it needs.
    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  len;
        logic        first;
        logic        last;
        logic [7:0]  seq;
        logic [7:0]  sys_id;
        logic [7:0]  comp_id;
        logic [23:0] msg_id;
        logic [7:0]  crc_seed;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] t;
        t = data ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

@@ rtl/core/mavlink_v2_frame_builder.sv @@
// MAVLink v2 unsigned frame builder.
// Payload bytes enter on the s_ channel, each with the frame's payload length;
// the length is sampled on a frame's first byte. Serialized frame bytes leave on
// the m_ channel, with m_tlast on the CRC high byte that closes each frame.
// Header registers (system id, component id, message id, CRC seed byte) are
// written through the cfg channel, index 0 to 3; other indexes are dropped.
// An accepted byte is classified and written into a four-entry queue; the
// serializer then emits one frame byte per cycle from the queue head while
// m_tready is high, so an accepted byte passes the queue and then the output
// register before m_tvalid rises. A frame's first byte yields the ten header
// bytes plus itself, a middle byte only itself, and the last byte itself plus
// the two CRC bytes. The output rate is one byte per cycle while m_tready is
// high; input waits only when the queue is full, e.g. behind a header burst.
// A frame start with zero length is taken and dropped.
// A stall on m_tready holds the output byte and backs up into the queue and then
// the input. Reset clears the queue, the sequence number and any frame in
// progress and restores the register defaults.
module mavlink_v2_frame_builder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] payload_byte, [15:8] payload_len
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_byte
    output logic        m_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    mvb_pkg::entry_t        push_entry;
    mvb_pkg::entry_t        head;
    mvb_pkg::queue_status_t q_status;
    logic                   q_push;
    logic                   q_pop;

    mvb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    mvb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .status     (q_status)
    );

    mvb_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/core/mvb_front.sv @@
module mvb_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [23:0]           cfg_data,
    input  mvb_pkg::queue_status_t q_status,
    output logic                  q_push,
    output mvb_pkg::entry_t       q_entry
);

    logic [7:0]  sys_id_reg;
    logic [7:0]  comp_id_reg;
    logic [23:0] msg_id_reg;
    logic [7:0]  crc_seed_reg;
    logic [7:0]  remaining_reg;
    logic [7:0]  remaining_next;
    logic [7:0]  seq_reg;
    logic [7:0]  seq_next;

    logic [7:0]  payload_byte;
    logic [7:0]  payload_len;
    logic        accept;
    logic        starting;
    logic [7:0]  remaining_eff;

    assign payload_byte = s_tdata[7:0];
    assign payload_len  = s_tdata[15:8];

    assign s_tready  = !q_status.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign starting  = (remaining_reg == 8'd0);

    always_comb
    begin
        remaining_eff  = starting ? payload_len : remaining_reg;
        remaining_next = remaining_reg;
        seq_next       = seq_reg;
        q_push         = 1'b0;
        // A frame start with zero length is taken and dropped.
        if (accept && (remaining_eff != 8'd0))
        begin
            q_push         = 1'b1;
            remaining_next = remaining_eff - 8'd1;
            if (starting)
            begin
                seq_next = seq_reg + 8'd1;
            end
        end
        q_entry.data     = payload_byte;
        q_entry.len      = payload_len;
        q_entry.first    = starting;
        q_entry.last     = (remaining_eff == 8'd1);
        q_entry.seq      = seq_reg;
        q_entry.sys_id   = sys_id_reg;
        q_entry.comp_id  = comp_id_reg;
        q_entry.msg_id   = msg_id_reg;
        q_entry.crc_seed = crc_seed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= 8'd0;
            seq_reg       <= 8'd0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            seq_reg       <= seq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_id_reg   <= mvb_pkg::RESET_SYS_ID;
            comp_id_reg  <= mvb_pkg::RESET_COMP_ID;
            msg_id_reg   <= mvb_pkg::RESET_MSG_ID;
            crc_seed_reg <= mvb_pkg::RESET_CRC_SEED;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mvb_pkg::REG_SYS_ID:   sys_id_reg   <= cfg_data[7:0];
                mvb_pkg::REG_COMP_ID:  comp_id_reg  <= cfg_data[7:0];
                mvb_pkg::REG_MSG_ID:   msg_id_reg   <= cfg_data;
                mvb_pkg::REG_CRC_SEED: crc_seed_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ rtl/core/mvb_queue.sv @@
module mvb_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mvb_pkg::entry_t        push_entry,
    input  logic                   pop,
    output mvb_pkg::entry_t        head,
    output mvb_pkg::queue_status_t status
);

    mvb_pkg::entry_t                slots_reg [mvb_pkg::QUEUE_DEPTH];
    logic [mvb_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [mvb_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [mvb_pkg::QUEUE_AW:0]     count_reg;
    logic [mvb_pkg::QUEUE_AW:0]     count_next;

    assign head         = slots_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (mvb_pkg::QUEUE_AW+1)'(mvb_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/mvb_back.sv @@
module mvb_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mvb_pkg::entry_t        head,
    input  mvb_pkg::queue_status_t q_status,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);

    logic            out_valid_reg;
    logic [7:0]      out_data_reg;
    logic            out_last_reg;
    mvb_pkg::phase_t phase_reg;
    mvb_pkg::phase_t phase_next;
    logic            started_reg;
    logic            started_next;
    logic [15:0]     crc_reg;
    logic [15:0]     crc_next;

    logic            advance;
    logic            fire;
    mvb_pkg::phase_t cur_phase;
    logic [7:0]      byte_out;
    logic [15:0]     crc_folded;
    logic            entry_done;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = !q_status.empty && advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // A frame's first byte walks the header first; others go straight to the payload.
    assign cur_phase  = started_reg ? phase_reg
                                    : (head.first ? mvb_pkg::PH_START : mvb_pkg::PH_PAYLOAD);
    assign crc_folded = mvb_pkg::x25_update(crc_reg, head.crc_seed);
    assign entry_done = ((cur_phase == mvb_pkg::PH_PAYLOAD) && !head.last)
                        || (cur_phase == mvb_pkg::PH_CRC_HI);
    assign q_pop      = fire && entry_done;

    always_comb
    begin
        case (cur_phase)
            mvb_pkg::PH_START:    byte_out = mvb_pkg::FRAME_START_BYTE;
            mvb_pkg::PH_LEN:      byte_out = head.len;
            mvb_pkg::PH_FLAGS_IN: byte_out = 8'h00;
            mvb_pkg::PH_FLAGS_CP: byte_out = 8'h00;
            mvb_pkg::PH_SEQ:      byte_out = head.seq;
            mvb_pkg::PH_SYS:      byte_out = head.sys_id;
            mvb_pkg::PH_COMP:     byte_out = head.comp_id;
            mvb_pkg::PH_MSG_LO:   byte_out = head.msg_id[7:0];
            mvb_pkg::PH_MSG_MID:  byte_out = head.msg_id[15:8];
            mvb_pkg::PH_MSG_HI:   byte_out = head.msg_id[23:16];
            mvb_pkg::PH_PAYLOAD:  byte_out = head.data;
            mvb_pkg::PH_CRC_LO:   byte_out = crc_folded[7:0];
            mvb_pkg::PH_CRC_HI:   byte_out = crc_reg[15:8];
            default:              byte_out = 8'h00;
        endcase
    end

    always_comb
    begin
        crc_next     = crc_reg;
        phase_next   = phase_reg;
        started_next = started_reg;
        if (fire)
        begin
            case (cur_phase)
                mvb_pkg::PH_START:  crc_next = mvb_pkg::CRC_INIT;
                mvb_pkg::PH_CRC_LO: crc_next = crc_folded;
                mvb_pkg::PH_CRC_HI: crc_next = crc_reg;
                default:            crc_next = mvb_pkg::x25_update(crc_reg, byte_out);
            endcase
            if (entry_done)
            begin
                started_next = 1'b0;
                phase_next   = mvb_pkg::PH_START;
            end
            else
            begin
                started_next = 1'b1;
                phase_next   = mvb_pkg::phase_t'(cur_phase + 4'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            phase_reg     <= mvb_pkg::PH_START;
            crc_reg       <= mvb_pkg::CRC_INIT;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            started_reg <= started_next;
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= byte_out;
            out_last_reg <= (cur_phase == mvb_pkg::PH_CRC_HI);
        end
    end

endmodule
